FILE: hw/rtl/bilinear_rotate_premultiply_defines.svh
// assertion macros for the bilinear rotate premultiply block
// used by the top level only
`ifndef BILINEAR_ROTATE_PREMULTIPLY_DEFINES_SVH
`define BILINEAR_ROTATE_PREMULTIPLY_DEFINES_SVH
`ifndef SYNTH
`define BRP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define BRP_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define BRP_ASSERT(lbl, clk, rst, prop)
`define BRP_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/brp_pkg.sv
// shared constants, types and helpers for the bilinear rotate premultiply block
// no dependencies
`timescale 1ns / 1ps
package brp_pkg;
   localparam int MaxSide = 64;
   localparam int CoordW = $clog2(MaxSide);
   localparam int HalfW = CoordW - 1;
   localparam int BankAddrW = 2 * HalfW;
   localparam int SideW = 7;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_COS = 2'd2;
   localparam logic [1:0] REG_SIN = 2'd3;

   // 4 banks by (y parity, x parity); each entry one ARGB pixel
   typedef struct packed {
      logic             wr_en;
      logic [1:0]       wr_bank;
      logic [BankAddrW-1:0] wr_addr;
      logic [31:0]      wr_data;
      logic [BankAddrW-1:0] rd_addr0;
      logic [BankAddrW-1:0] rd_addr1;
      logic [BankAddrW-1:0] rd_addr2;
      logic [BankAddrW-1:0] rd_addr3;
   } mem_req_type;

   // divide a product up to 255*255 by 255, floor
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] t;
      begin
         t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
         div255 = t[15:8];
      end
   endfunction
endpackage

FILE: hw/rtl/brp_image_mem.sv
// source image held in four parity banks, one read per bank per cycle
// depends on brp_pkg
`timescale 1ns / 1ps
module brp_image_mem (
   input  logic                  clock,
   input  brp_pkg::mem_req_type  req,
   output logic [31:0]           rd_data_ff [4]
);
   localparam int Depth = 1 << brp_pkg::BankAddrW;
   logic [31:0] bank0 [Depth];
   logic [31:0] bank1 [Depth];
   logic [31:0] bank2 [Depth];
   logic [31:0] bank3 [Depth];

   always_ff @(posedge clock) begin
      if (req.wr_en && req.wr_bank == 2'd0) bank0[req.wr_addr] <= req.wr_data;
      if (req.wr_en && req.wr_bank == 2'd1) bank1[req.wr_addr] <= req.wr_data;
      if (req.wr_en && req.wr_bank == 2'd2) bank2[req.wr_addr] <= req.wr_data;
      if (req.wr_en && req.wr_bank == 2'd3) bank3[req.wr_addr] <= req.wr_data;
      rd_data_ff[0] <= bank0[req.rd_addr0];
      rd_data_ff[1] <= bank1[req.rd_addr1];
      rd_data_ff[2] <= bank2[req.rd_addr2];
      rd_data_ff[3] <= bank3[req.rd_addr3];
   end
endmodule

FILE: hw/rtl/brp_blend.sv
// per-channel bilinear blend and premultiply, pipelined over three stages
// depends on brp_pkg
`timescale 1ns / 1ps
module brp_blend (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] tl,
   input  logic [31:0] tr,
   input  logic [31:0] bl,
   input  logic [31:0] br,
   input  logic [7:0]  fx,
   input  logic [7:0]  fy,
   output logic [31:0] pixel_ff
);
   logic [16:0] top_ff [4];
   logic [16:0] bot_ff [4];
   logic [7:0]  fy_ff;
   logic [7:0]  chan_ff [4];
   logic [31:0] pixel_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int c = 0; c < 4; c++) begin
            top_ff[c] <= 17'((9'd256 - {1'b0, fx}) * tl[c*8 +: 8]) + 17'(fx * tr[c*8 +: 8]);
            bot_ff[c] <= 17'((9'd256 - {1'b0, fx}) * bl[c*8 +: 8]) + 17'(fx * br[c*8 +: 8]);
         end
         fy_ff <= fy;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int c = 0; c < 4; c++) begin
            chan_ff[c] <= 8'((26'((9'd256 - {1'b0, fy_ff}) * top_ff[c])
                          + 26'(fy_ff * bot_ff[c]) + 26'd32768) >> 16);
         end
      end
   end

   always_comb begin
      pixel_in[7:0] = chan_ff[3];
      pixel_in[31:24] = brp_pkg::div255(16'(chan_ff[2] * chan_ff[3]));
      pixel_in[23:16] = brp_pkg::div255(16'(chan_ff[1] * chan_ff[3]));
      pixel_in[15:8] = brp_pkg::div255(16'(chan_ff[0] * chan_ff[3]));
   end

   always_ff @(posedge clock) begin
      if (enable) pixel_ff <= pixel_in;
   end
endmodule

FILE: hw/rtl/bilinear_rotate_premultiply.sv
// top level of the bilinear rotate premultiply block
// depends on brp_pkg, brp_image_mem, brp_blend and the assertion header
`timescale 1ns / 1ps
`include "bilinear_rotate_premultiply_defines.svh"
// Takes one request per clock while not stalled: loads write one pixel into one
// of four parity-split image banks, queries rotate their coordinate, read the
// four neighbours in the same cycle (one per bank) and blend them; loads produce
// no result. The whole pipeline advances together and stalls only when the
// result register is full and not taken. A load reaching memory before a later
// query's read is seen by that read because the write and read happen in order
// on the same pipeline stage.
module bilinear_rotate_premultiply (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // func
   input  logic [47:0] req_tdata,   // pos_x[5:0], pos_y[11:6], source_pixel[43:12], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_out
   output logic        rsp_tuser,   // inside_res
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int CW = brp_pkg::CoordW;
   logic [6:0] width_ff, height_ff;
   logic signed [15:0] cos_ff, sin_ff;
   logic [1:0] reg_idx;
   assign reg_idx = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 7'd64; height_ff <= 7'd64; cos_ff <= 16'sd16384; sin_ff <= 16'sd0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            brp_pkg::REG_WIDTH:  width_ff <= csr_pwdata[6:0];
            brp_pkg::REG_HEIGHT: height_ff <= csr_pwdata[6:0];
            brp_pkg::REG_COS:    cos_ff <= csr_pwdata[15:0];
            brp_pkg::REG_SIN:    sin_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         brp_pkg::REG_WIDTH:  csr_prdata = {25'd0, width_ff};
         brp_pkg::REG_HEIGHT: csr_prdata = {25'd0, height_ff};
         brp_pkg::REG_COS:    csr_prdata = {16'd0, cos_ff};
         default:             csr_prdata = {16'd0, sin_ff};
      endcase
   end

   // clamped sides and centre
   logic [6:0] w_eff, h_eff;
   assign w_eff = (width_ff == 7'd0) ? 7'd1 : (width_ff > 7'd64) ? 7'd64 : width_ff;
   assign h_eff = (height_ff == 7'd0) ? 7'd1 : (height_ff > 7'd64) ? 7'd64 : height_ff;

   // global advance: pipeline moves unless the result register is stuck
   logic adv;
   logic out_valid_ff;
   assign adv = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   logic acc;
   assign acc = req_tvalid && req_tready;

   // stage 1: offsets and products
   logic v1_ff, q1_ff, out1_ff;
   logic [CW-1:0] lx1_ff, ly1_ff;
   logic [31:0] pix1_ff;
   logic signed [23:0] p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff;
   logic signed [7:0] ox, oy;
   assign ox = $signed({2'b0, req_tdata[5:0]}) - $signed({2'b0, w_eff[6:1]});
   assign oy = $signed({2'b0, req_tdata[11:6]}) - $signed({2'b0, h_eff[6:1]});

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= acc;
      if (adv) begin
         q1_ff <= req_tuser;
         lx1_ff <= req_tdata[5:0]; ly1_ff <= req_tdata[11:6];
         pix1_ff <= req_tdata[43:12];
         out1_ff <= ({1'b0, req_tdata[5:0]} >= w_eff) || ({1'b0, req_tdata[11:6]} >= h_eff);
         p_xc_ff <= ox * cos_ff; p_ys_ff <= oy * sin_ff;
         p_xs_ff <= ox * sin_ff; p_yc_ff <= oy * cos_ff;
      end
   end

   // stage 2: rotated coordinate in Q8, range test, bank addresses
   logic signed [24:0] sx, sy;
   logic signed [18:0] rx, ry;
   assign sx = 25'(p_xc_ff) - 25'(p_ys_ff);
   assign sy = 25'(p_xs_ff) + 25'(p_yc_ff);
   assign rx = 19'(sx >>> 6) + 19'({w_eff[6:1], 8'd0});
   assign ry = 19'(sy >>> 6) + 19'({h_eff[6:1], 8'd0});
   logic inside2;
   assign inside2 = !out1_ff && !rx[18] && !ry[18]
      && (rx < $signed({5'd0, 6'(w_eff - 7'd1), 8'd0}))
      && (ry < $signed({5'd0, 6'(h_eff - 7'd1), 8'd0}));
   logic [CW-1:0] ix, iy, jx, jy;
   assign ix = rx[8 +: CW];
   assign iy = ry[8 +: CW];
   assign jx = (rx[7:0] != 8'd0) ? ix + 1'b1 : ix;
   assign jy = (ry[7:0] != 8'd0) ? iy + 1'b1 : iy;

   // per bank (yb,xb): pick whichever of i/j has that parity
   logic [CW-1:0] bx0, bx1, by0, by1;
   assign bx0 = ix[0] ? jx : ix;
   assign bx1 = ix[0] ? ix : jx;
   assign by0 = iy[0] ? jy : iy;
   assign by1 = iy[0] ? iy : jy;

   brp_pkg::mem_req_type mreq;
   always_comb begin
      mreq.wr_en = v1_ff && adv && (q1_ff == brp_pkg::FUNC_LOAD);
      mreq.wr_bank = {ly1_ff[0], lx1_ff[0]};
      mreq.wr_addr = {ly1_ff[CW-1:1], lx1_ff[CW-1:1]};
      mreq.wr_data = pix1_ff;
      mreq.rd_addr0 = {by0[CW-1:1], bx0[CW-1:1]};
      mreq.rd_addr1 = {by0[CW-1:1], bx1[CW-1:1]};
      mreq.rd_addr2 = {by1[CW-1:1], bx0[CW-1:1]};
      mreq.rd_addr3 = {by1[CW-1:1], bx1[CW-1:1]};
   end

   // hold read address on stall: re-present last address
   brp_pkg::mem_req_type mreq_hold_ff, mreq_mem;
   always_ff @(posedge clock) if (adv) mreq_hold_ff <= mreq;
   always_comb begin
      mreq_mem = adv ? mreq : mreq_hold_ff;
      mreq_mem.wr_en = mreq.wr_en;
   end

   logic [31:0] rd_data [4];
   brp_image_mem u_mem (.clock(clock), .req(mreq_mem), .rd_data_ff(rd_data));

   // stage 3 (memory data valid)
   logic v3_ff, in3_ff, xs3_ff, ys3_ff;
   logic [7:0] fx3_ff, fy3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v1_ff && (q1_ff == brp_pkg::FUNC_QUERY);
      if (adv) begin
         in3_ff <= inside2; xs3_ff <= ix[0]; ys3_ff <= iy[0];
         fx3_ff <= rx[7:0]; fy3_ff <= ry[7:0];
      end
   end

   logic [31:0] tl, tr, bl, br;
   logic [31:0] row_i [2], row_j [2];
   always_comb begin
      row_i[0] = ys3_ff ? rd_data[2] : rd_data[0];
      row_i[1] = ys3_ff ? rd_data[3] : rd_data[1];
      row_j[0] = ys3_ff ? rd_data[0] : rd_data[2];
      row_j[1] = ys3_ff ? rd_data[1] : rd_data[3];
      tl = xs3_ff ? row_i[1] : row_i[0];
      tr = xs3_ff ? row_i[0] : row_i[1];
      bl = xs3_ff ? row_j[1] : row_j[0];
      br = xs3_ff ? row_j[0] : row_j[1];
   end

   logic [31:0] blend_pix;
   brp_blend u_blend (.clock(clock), .enable(adv), .tl(tl), .tr(tr), .bl(bl), .br(br),
      .fx(fx3_ff), .fy(fy3_ff), .pixel_ff(blend_pix));

   // carry valid and inside alongside the blend pipeline
   logic [2:0] vd_ff, id_ff;
   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 3'd0;
      else if (adv) vd_ff <= {vd_ff[1:0], v3_ff};
      if (adv) id_ff <= {id_ff[1:0], in3_ff};
   end

   logic [31:0] out_pix_ff;
   logic out_in_ff;
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= vd_ff[2];
      if (adv) begin
         out_pix_ff <= id_ff[2] ? blend_pix : 32'd0;
         out_in_ff <= id_ff[2];
      end
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_pix_ff;
   assign rsp_tuser = out_in_ff;

   `BRP_ASSERT(a_stall_holds, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
   `BRP_ASSERT(a_ready_when_free, clock, reset, !rsp_tvalid |-> req_tready)
   `BRP_ASSERT(a_outside_zero, clock, reset, (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 32'd0))
endmodule
